// File: sv/lts_pkg.sv
package lts_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 8;
  localparam int ENTRY_BITS  = KEY_BITS + 1;
  localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RES     = QUEUE_DEPTH + 1;
  localparam int RW          = $clog2(MAX_RES + 1);
  localparam int RIW         = $clog2(MAX_RES);

  typedef logic [1:0] qid_t;

  typedef enum logic [1:0] {
    FN_INIT   = 2'd0,
    FN_SCHED  = 2'd1,
    FN_NEXT   = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_BREF_SET = 2'd1,
    KIND_BREF_NIL = 2'd2,
    KIND_OTHER    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    EV_ACCEPTED = 4'd0,
    EV_DUP      = 4'd1,
    EV_FULL     = 4'd2,
    EV_KILLED   = 4'd3,
    EV_GIVEN    = 4'd4,
    EV_NONE     = 4'd5,
    EV_REMOVED  = 4'd6,
    EV_NONE_REM = 4'd7,
    EV_INIT     = 4'd8
  } ev_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SCHED,
    S_NCHK,
    S_NFETCH,
    S_NDATA,
    S_REM,
    S_RDATA,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LATCH,
    OP_INIT,
    OP_SCAN_IN,
    OP_SCAN_STEP,
    OP_SCHED,
    OP_ROTATE,
    OP_FETCH,
    OP_GIVE,
    OP_WALK,
    OP_NONE_RES,
    OP_REM_POP,
    OP_REM_PUSH,
    OP_NONE_REM
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_pop;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  scan_fin;
    logic  walk;
    logic  exhausted;
    logic  cur_avail;
    logic  walk_char;
    logic  res_empty;
    logic  res_last;
  } status_t;

endpackage

// File: sv/lts_ram.sv
module lts_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 9
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lts_ctrl.sv
module lts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lts_pkg::status_t  st,
  output lts_pkg::cmd_t     cmd
);

  lts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lts_pkg::S_IDLE: begin
        if (in_valid) state_next = lts_pkg::S_DISPATCH;
      end
      lts_pkg::S_DISPATCH: begin
        unique case (st.func)
          lts_pkg::FN_INIT:   state_next = lts_pkg::S_OUT;
          lts_pkg::FN_SCHED:  state_next = lts_pkg::S_SCAN;
          lts_pkg::FN_NEXT:   state_next = lts_pkg::S_NCHK;
          lts_pkg::FN_REMOVE: state_next = lts_pkg::S_REM;
          default:            state_next = lts_pkg::S_OUT;
        endcase
      end
      lts_pkg::S_SCAN: begin
        if (st.scan_fin) state_next = lts_pkg::S_SCHED;
      end
      lts_pkg::S_SCHED: begin
        state_next = st.walk ? lts_pkg::S_NCHK : lts_pkg::S_OUT;
      end
      lts_pkg::S_NCHK: state_next = lts_pkg::S_NFETCH;
      lts_pkg::S_NFETCH: begin
        state_next = st.cur_avail ? lts_pkg::S_NDATA : lts_pkg::S_OUT;
      end
      lts_pkg::S_NDATA: begin
        state_next = st.walk_char ? lts_pkg::S_SCAN : lts_pkg::S_OUT;
      end
      lts_pkg::S_REM: begin
        state_next = st.cur_avail ? lts_pkg::S_RDATA : lts_pkg::S_OUT;
      end
      lts_pkg::S_RDATA: state_next = lts_pkg::S_REM;
      lts_pkg::S_OUT: begin
        if (out_ready && st.res_last) state_next = lts_pkg::S_IDLE;
      end
      default: state_next = lts_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op      = lts_pkg::OP_IDLE;
    cmd.out_pop = 1'b0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state)
      lts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = lts_pkg::OP_LATCH;
      end
      lts_pkg::S_DISPATCH: begin
        if (st.func == lts_pkg::FN_INIT) cmd.op = lts_pkg::OP_INIT;
        else if (st.func == lts_pkg::FN_SCHED) cmd.op = lts_pkg::OP_SCAN_IN;
      end
      lts_pkg::S_SCAN:  cmd.op = lts_pkg::OP_SCAN_STEP;
      lts_pkg::S_SCHED: cmd.op = lts_pkg::OP_SCHED;
      lts_pkg::S_NCHK: begin
        if (st.exhausted) cmd.op = lts_pkg::OP_ROTATE;
      end
      lts_pkg::S_NFETCH: begin
        cmd.op = st.cur_avail ? lts_pkg::OP_FETCH : lts_pkg::OP_NONE_RES;
      end
      lts_pkg::S_NDATA: begin
        cmd.op = st.walk_char ? lts_pkg::OP_WALK : lts_pkg::OP_GIVE;
      end
      lts_pkg::S_REM: begin
        if (st.cur_avail) cmd.op = lts_pkg::OP_REM_POP;
        else if (st.res_empty) cmd.op = lts_pkg::OP_NONE_REM;
      end
      lts_pkg::S_RDATA: cmd.op = lts_pkg::OP_REM_PUSH;
      lts_pkg::S_OUT: begin
        out_valid   = 1'b1;
        cmd.out_pop = out_ready;
      end
      default: cmd.op = lts_pkg::OP_IDLE;
    endcase
  end

endmodule

// File: sv/lts_dp.sv
module lts_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  lts_pkg::cmd_t                cmd,
  input  logic [1:0]                   in_func,
  input  logic [7:0]                   in_key,
  input  logic [1:0]                   in_kind,
  output lts_pkg::status_t             st,
  output logic [3:0]                   out_event,
  output logic [7:0]                   out_thread,
  output logic                         work_left,
  output logic                         done_step
);

  localparam int KB = lts_pkg::KEY_BITS;
  localparam int EB = lts_pkg::ENTRY_BITS;
  localparam int AW = lts_pkg::AW;
  localparam int CW = lts_pkg::CW;
  localparam int RW = lts_pkg::RW;
  localparam int RIW = lts_pkg::RIW;

  // queue bookkeeping
  logic [CW-1:0] cur_count, next_count, sync_count, cursor;
  logic          lock;
  lts_pkg::qid_t cur_id, nxt_id, syn_id;

  // latched item and scan state
  lts_pkg::func_t func_r;
  lts_pkg::kind_t in_kind_r;
  logic [KB-1:0]  key_r;
  logic           char_path, char_flag, walk, dup;
  logic [CW-1:0]  idx, idx_q, kills;
  logic           pend;

  // result buffer
  logic [4+8-1:0] res_buf [lts_pkg::MAX_RES];
  logic [RW-1:0]  res_cnt;
  logic [RIW-1:0] rd_ptr;

  // queue memories
  logic [EB-1:0] rd [3];
  logic          wr_en;
  lts_pkg::qid_t tgt_id;
  logic [CW-1:0] tcnt;
  logic [AW-1:0] cur_addr;
  logic [CW-1:0] cur_dec;

  assign cur_dec  = cur_count - CW'(1);
  assign cur_addr = (cmd.op == lts_pkg::OP_REM_POP) ? cur_dec[AW-1:0] : cursor[AW-1:0];

  for (genvar g = 0; g < 3; g++) begin : g_q
    lts_ram #(.DEPTH(lts_pkg::QUEUE_DEPTH), .WIDTH(EB)) u_ram (
      .clk   (clk),
      .we    (wr_en && (tgt_id == lts_pkg::qid_t'(g))),
      .waddr (tcnt[AW-1:0]),
      .wdata ({char_flag, key_r}),
      .raddr ((cur_id == lts_pkg::qid_t'(g)) ? cur_addr : idx[AW-1:0]),
      .rdata (rd[g])
    );
  end

  // duplicate scan over next and sync, one entry per cycle
  logic [CW-1:0] maxc;
  logic          issue, hit;
  logic [EB-1:0] rdn, rds, rdc;

  assign maxc  = (next_count > sync_count) ? next_count : sync_count;
  assign issue = idx < maxc;
  assign rdn   = rd[nxt_id];
  assign rds   = rd[syn_id];
  assign rdc   = rd[cur_id];
  assign hit   = pend && (((idx_q < next_count) && (rdn[KB-1:0] == key_r)) ||
                          ((idx_q < sync_count) && (rds[KB-1:0] == key_r)));

  // routing and result of a schedule
  logic          tgt_sync;
  lts_pkg::ev_t  sres;

  assign tgt_sync = char_path && (next_count == '0);
  assign tgt_id   = tgt_sync ? syn_id : nxt_id;
  assign tcnt     = tgt_sync ? sync_count : next_count;
  always_comb begin
    priority if (dup) sres = lts_pkg::EV_DUP;
    else if (tcnt == CW'(lts_pkg::QUEUE_DEPTH)) sres = lts_pkg::EV_FULL;
    else sres = lts_pkg::EV_ACCEPTED;
  end
  assign wr_en = (cmd.op == lts_pkg::OP_SCHED) && (sres == lts_pkg::EV_ACCEPTED);

  // result push
  logic          push;
  lts_pkg::ev_t  push_ev;
  logic [7:0]    push_key;

  always_comb begin
    push     = 1'b0;
    push_ev  = lts_pkg::EV_NONE;
    push_key = '0;
    unique case (cmd.op)
      lts_pkg::OP_INIT: begin
        push    = 1'b1;
        push_ev = lts_pkg::EV_INIT;
      end
      lts_pkg::OP_SCHED: begin
        if (walk) begin
          push     = (sres != lts_pkg::EV_ACCEPTED) &&
                     (kills < CW'(lts_pkg::QUEUE_DEPTH));
          push_ev  = lts_pkg::EV_KILLED;
          push_key = 8'(key_r);
        end else begin
          push     = 1'b1;
          push_ev  = sres;
          push_key = (sres == lts_pkg::EV_ACCEPTED) ? 8'(key_r) : 8'd0;
        end
      end
      lts_pkg::OP_GIVE: begin
        push     = 1'b1;
        push_ev  = lts_pkg::EV_GIVEN;
        push_key = 8'(rdc[KB-1:0]);
      end
      lts_pkg::OP_NONE_RES: begin
        push    = 1'b1;
        push_ev = lts_pkg::EV_NONE;
      end
      lts_pkg::OP_REM_PUSH: begin
        push     = 1'b1;
        push_ev  = lts_pkg::EV_REMOVED;
        push_key = 8'(rdc[KB-1:0]);
      end
      lts_pkg::OP_NONE_REM: begin
        push    = 1'b1;
        push_ev = lts_pkg::EV_NONE_REM;
      end
      default: push = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_count  <= '0;
      next_count <= '0;
      sync_count <= '0;
      cursor     <= '0;
      lock       <= 1'b0;
      cur_id     <= 2'd0;
      nxt_id     <= 2'd1;
      syn_id     <= 2'd2;
      res_cnt    <= '0;
      rd_ptr     <= '0;
      kills      <= '0;
      idx        <= '0;
      pend       <= 1'b0;
      dup        <= 1'b0;
    end else begin
      if (push && (res_cnt < RW'(lts_pkg::MAX_RES))) begin
        res_cnt <= res_cnt + RW'(1);
      end
      if (cmd.out_pop) begin
        rd_ptr <= rd_ptr + RIW'(1);
      end
      unique case (cmd.op)
        lts_pkg::OP_LATCH: begin
          res_cnt <= '0;
          rd_ptr  <= '0;
          kills   <= '0;
        end
        lts_pkg::OP_INIT: begin
          cursor <= '0;
          lock   <= 1'b0;
        end
        lts_pkg::OP_SCAN_IN, lts_pkg::OP_WALK: begin
          idx  <= '0;
          pend <= 1'b0;
          dup  <= 1'b0;
        end
        lts_pkg::OP_SCAN_STEP: begin
          if (issue) idx <= idx + CW'(1);
          pend <= issue;
          if (hit) dup <= 1'b1;
        end
        lts_pkg::OP_SCHED: begin
          if (wr_en) begin
            if (tgt_sync) sync_count <= sync_count + CW'(1);
            else next_count <= next_count + CW'(1);
          end
          if (walk && push) kills <= kills + CW'(1);
        end
        lts_pkg::OP_ROTATE: begin
          cursor <= '0;
          if (next_count == '0) begin
            lock       <= 1'b1;
            cur_id     <= syn_id;
            syn_id     <= cur_id;
            cur_count  <= sync_count;
            sync_count <= '0;
          end else begin
            lock       <= 1'b0;
            cur_id     <= nxt_id;
            nxt_id     <= cur_id;
            cur_count  <= next_count;
            next_count <= '0;
          end
        end
        lts_pkg::OP_FETCH:   cursor <= cursor + CW'(1);
        lts_pkg::OP_REM_POP: cur_count <= cur_dec;
        default: ;
      endcase
    end
  end

  // kind held from the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.op == lts_pkg::OP_LATCH) begin
      in_kind_r <= lts_pkg::kind_t'(in_kind);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == lts_pkg::OP_LATCH) begin
      func_r <= lts_pkg::func_t'(in_func);
      key_r  <= KB'(in_key);
    end
    if (cmd.op == lts_pkg::OP_SCAN_IN) begin
      char_path <= (in_kind_r == lts_pkg::KIND_CHAR) || (in_kind_r == lts_pkg::KIND_BREF_SET);
      char_flag <= (in_kind_r == lts_pkg::KIND_CHAR);
      walk      <= 1'b0;
    end
    if (cmd.op == lts_pkg::OP_WALK) begin
      key_r     <= rdc[KB-1:0];
      char_path <= 1'b1;
      char_flag <= 1'b1;
      walk      <= 1'b1;
    end
    if (cmd.op == lts_pkg::OP_SCAN_STEP) begin
      idx_q <= idx;
    end
    if (push && (res_cnt < RW'(lts_pkg::MAX_RES))) begin
      res_buf[res_cnt[RIW-1:0]] <= {push_ev, push_key};
    end
  end

  // status back to the controller
  assign st.func      = func_r;
  assign st.scan_fin  = hit || (!issue && !pend);
  assign st.walk      = walk;
  assign st.exhausted = cursor >= cur_count;
  assign st.cur_avail = cursor < cur_count;
  assign st.walk_char = rdc[KB] && !lock;
  assign st.res_empty = res_cnt == '0;
  assign st.res_last  = (RW'(rd_ptr) + RW'(1)) == res_cnt;

  // result beat
  assign out_event  = res_buf[rd_ptr][11:8];
  assign out_thread = res_buf[rd_ptr][7:0];
  assign work_left  = (cursor < cur_count) || (next_count != '0) || (sync_count != '0);
  assign done_step  = (cursor >= cur_count) && lock;

endmodule

// File: sv/lockstep_thread_scheduler.sv
// Channel  Dir  Beat
// s_*      in   tdata: thread_key[7:0], thread_kind[9:8]; tuser: func[1:0]
// m_*      out  tdata: out_thread[7:0], work_left[8], done_step[9];
//               tuser: event_res[3:0]; tlast: last result of the item
//
// One item at a time: s_tready is high only when idle.
// Schedule: a duplicate scan over next and sync at one entry per cycle, then the schedule step.
// Next: check, fetch and data states per walked entry plus a scan per rescheduled one.
// Remove: pop and data states per popped entry. Then one result beat per cycle while m_tready is high.
// Reset (rst, synchronous) empties all queues; queue memories are not cleared.
// m_tready low holds the current result beat; no input is taken meanwhile.
module lockstep_thread_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // thread_key[7:0], thread_kind[9:8], zeros
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_thread[7:0], work_left[8], done_step[9], zeros
  output logic [3:0]  m_tuser,   // event_res[3:0]
  output logic        m_tlast
);

  lts_pkg::cmd_t    cmd;
  lts_pkg::status_t st;
  logic [7:0]       out_thread;
  logic             work_left, done_step;

  lts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lts_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_func    (s_tuser),
    .in_key     (s_tdata[7:0]),
    .in_kind    (s_tdata[9:8]),
    .st         (st),
    .out_event  (m_tuser),
    .out_thread (out_thread),
    .work_left  (work_left),
    .done_step  (done_step)
  );

  assign m_tdata = {6'd0, done_step, work_left, out_thread};
  assign m_tlast = st.res_last;

`ifndef SYNTH
  // a result beat is never offered with an empty buffer
  a_out_has_res: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !st.res_empty) else $error("result beat with empty buffer");

  // input and output sides never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready)) else $error("input taken while results pending");

  // an accepted item closes the input side
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");

  // the last result beat returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("not idle after last");
`endif

endmodule
